// ----- design/pdde_pkg.sv -----
package pdde_pkg;

  localparam int NumChunks   = 8;
  localparam int ChunkW      = 24;
  localparam int SumW        = 50;
  localparam int IdxW        = 3;
  localparam int CntW        = 4;
  localparam logic [23:0] ChunkBase    = 24'd10000000;
  localparam logic [25:0] TwoChunkBase = 26'd20000000;
  // floor(2^48 / 78125): quotient estimate of v / 10^7 from v[49:23]
  localparam logic [31:0] QuotRecip    = 32'd3602879701;
  // ceil(2^40 / 78125): exact quotient of x / 78125 for 24-bit x
  localparam logic [23:0] SplitRecip   = 24'd14073749;
  // ceil(2^27 / 10): exact quotient of x / 10 for 24-bit x
  localparam logic [23:0] TenRecip     = 24'd13421773;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_CHECK,
    ST_MUL_CLR,
    ST_MUL_ACC,
    ST_NORM,
    ST_NORM_Q,
    ST_NORM_R,
    ST_NORM_WR,
    ST_NEXT,
    ST_DIGIT,
    ST_DONE
  } pdde_state_t;

  typedef enum logic [1:0] {
    DST_POWER,
    DST_SQUARE
  } pdde_dst_t;

  typedef struct packed {
    logic             load;
    logic             split;
    logic             mul_clear;
    logic             mul_acc;
    logic             mul_dst_sq;
    logic [IdxW-1:0]  i;
    logic [IdxW-1:0]  j;
    logic             norm_load;
    logic             norm_quot;
    logic             norm_rem;
    logic             norm;
    logic [IdxW-1:0]  norm_idx;
    logic             shift_exp;
    logic             digit_step;
  } pdde_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_gt1;
    logic split_done;
    logic digit_done;
  } pdde_status_t;

endpackage

// ----- design/pdde_ctrl.sv -----
module pdde_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pdde_pkg::pdde_cmd_t   cmd,
  input  pdde_pkg::pdde_status_t status
);
  import pdde_pkg::*;

  pdde_state_t state, state_next;
  logic [IdxW-1:0] i, i_next, j, j_next;
  logic            sq_phase, sq_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      i        <= '0;
      j        <= '0;
      sq_phase <= 1'b0;
    end else begin
      state    <= state_next;
      i        <= i_next;
      j        <= j_next;
      sq_phase <= sq_phase_next;
    end
  end

  always_comb begin
    state_next    = state;
    i_next        = i;
    j_next        = j;
    sq_phase_next = sq_phase;
    cmd           = '0;
    cmd.i         = i;
    cmd.j         = j;
    cmd.norm_idx  = i;
    cmd.mul_dst_sq = sq_phase;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        if (status.split_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.exp_zero) begin
          state_next = ST_DIGIT;
        end else if (status.exp_lsb) begin
          sq_phase_next = 1'b0;
          state_next    = ST_MUL_CLR;
        end else if (status.exp_gt1) begin
          sq_phase_next = 1'b1;
          state_next    = ST_MUL_CLR;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_MUL_CLR: begin
        cmd.mul_clear = 1'b1;
        i_next        = '0;
        j_next        = '0;
        state_next    = ST_MUL_ACC;
      end
      ST_MUL_ACC: begin
        cmd.mul_acc = 1'b1;
        if ({1'b0, i} + {1'b0, j} == CntW'(NumChunks - 1)) begin
          j_next = '0;
          if (i == IdxW'(NumChunks - 1)) begin
            i_next     = '0;
            state_next = ST_NORM;
          end else begin
            i_next = i + 1'b1;
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      ST_NORM: begin
        cmd.norm_load = 1'b1;
        state_next    = ST_NORM_Q;
      end
      ST_NORM_Q: begin
        cmd.norm_quot = 1'b1;
        state_next    = ST_NORM_R;
      end
      ST_NORM_R: begin
        cmd.norm_rem = 1'b1;
        state_next   = ST_NORM_WR;
      end
      ST_NORM_WR: begin
        cmd.norm = 1'b1;
        if (i == IdxW'(NumChunks - 1)) begin
          i_next = '0;
          if (!sq_phase && status.exp_gt1) begin
            sq_phase_next = 1'b1;
            state_next    = ST_MUL_CLR;
          end else begin
            state_next = ST_NEXT;
          end
        end else begin
          i_next     = i + 1'b1;
          state_next = ST_NORM;
        end
      end
      ST_NEXT: begin
        cmd.shift_exp = 1'b1;
        state_next    = ST_CHECK;
      end
      ST_DIGIT: begin
        cmd.digit_step = 1'b1;
        if (status.digit_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_SPLIT)) else $error("load without split");
`endif

endmodule

// ----- design/pdde_dp.sv -----
module pdde_dp (
  input  logic                   clk,
  input  logic [30:0]            base_value,
  input  logic [63:0]            power,
  input  logic [5:0]             digit_position,
  input  pdde_pkg::pdde_cmd_t    cmd,
  output pdde_pkg::pdde_status_t status,
  output logic [3:0]             digit
);
  import pdde_pkg::*;

  logic [ChunkW-1:0] pw [NumChunks];
  logic [ChunkW-1:0] sq [NumChunks];
  logic [SumW-1:0]   ps [NumChunks];
  logic [63:0]       exp_left;
  logic [30:0]       base_rem;
  logic [IdxW-1:0]   split_idx;
  logic [5:0]        pos;
  logic [5:0]        digit_cnt;
  logic [ChunkW-1:0] dchunk;
  logic              dinit;
  logic [SumW-1:0]   carry;
  logic [47:0]       prod_r;
  logic [IdxW-1:0]   acc_k;
  logic              acc_v;
  logic [SumW-1:0]   vsum;
  logic [SumW-1:0]   nv;
  logic [58:0]       nq_prod;
  logic [26:0]       nq;
  logic [25:0]       nr;
  logic [25:0]       nr_fix;
  logic [1:0]        nfix;
  logic [47:0]       sp_prod;
  logic [7:0]        sp_q;
  logic [30:0]       sp_r;
  logic [47:0]       dq_prod;
  logic [ChunkW-1:0] dq;
  logic [5:0]        pm1;
  logic [11:0]       pmul;
  logic [3:0]        pq;
  logic [5:0]        poff_full;
  logic [ChunkW-1:0] a_sel, b_sel;
  logic [3:0]        pdig;
  logic [2:0]        pidx;
  logic [2:0]        poff;

  assign a_sel = cmd.mul_dst_sq ? sq[cmd.i] : pw[cmd.i];
  assign b_sel = sq[cmd.j];

  // v / 10^7: estimate from the top bits, then at most two subtractions
  assign vsum    = ps[cmd.norm_idx] + carry;
  assign nq_prod = 59'(nv[49:23]) * 59'(QuotRecip);
  always_comb begin
    if (nr >= TwoChunkBase) begin
      nfix   = 2'd2;
      nr_fix = nr - TwoChunkBase;
    end else if (nr >= 26'(ChunkBase)) begin
      nfix   = 2'd1;
      nr_fix = nr - 26'(ChunkBase);
    end else begin
      nfix   = 2'd0;
      nr_fix = nr;
    end
  end

  assign sp_prod = 48'(base_rem[30:7]) * 48'(SplitRecip);
  assign sp_q    = sp_prod[47:40];
  assign sp_r    = base_rem - 31'(sp_q) * 31'(ChunkBase);

  assign dq_prod = 48'(dchunk) * 48'(TenRecip);
  assign dq      = ChunkW'(dq_prod[47:27]);

  assign pm1       = pos - 6'd1;
  assign pmul      = 12'(pm1) * 12'd37;
  assign pq        = pmul[11:8];
  assign poff_full = pm1 - 6'(pq) * 6'd7;
  assign pidx      = pq[2:0];
  assign poff      = poff_full[2:0];

  always_ff @(posedge clk) begin
    acc_v  <= cmd.mul_acc;
    acc_k  <= cmd.i + cmd.j;
    prod_r <= a_sel * b_sel;
    if (cmd.load) begin
      base_rem  <= base_value;
      exp_left  <= power;
      pos       <= digit_position;
      split_idx <= '0;
      for (int k = 0; k < NumChunks; k++) begin
        pw[k] <= (k == 0) ? ChunkW'(1) : '0;
      end
    end
    if (cmd.split) begin
      sq[split_idx] <= ChunkW'(sp_r);
      base_rem      <= 31'(sp_q);
      split_idx     <= split_idx + 1'b1;
      dinit         <= 1'b1;
    end
    if (cmd.mul_clear) begin
      for (int k = 0; k < NumChunks; k++) ps[k] <= '0;
      carry <= '0;
    end
    if (acc_v) ps[acc_k] <= ps[acc_k] + SumW'(prod_r);
    if (cmd.norm_load) nv <= vsum;
    if (cmd.norm_quot) nq <= nq_prod[58:32];
    if (cmd.norm_rem)  nr <= nv[25:0] - nq[25:0] * 26'(ChunkBase);
    if (cmd.norm) begin
      if (cmd.mul_dst_sq) sq[cmd.norm_idx] <= ChunkW'(nr_fix);
      else                pw[cmd.norm_idx] <= ChunkW'(nr_fix);
      carry <= SumW'(nq) + SumW'(nfix);
    end
    if (cmd.shift_exp) exp_left <= exp_left >> 1;
    if (cmd.digit_step) begin
      if (dinit) begin
        dinit     <= 1'b0;
        dchunk    <= pw[pidx];
        digit_cnt <= 6'(poff);
      end else if (digit_cnt != 0) begin
        dchunk    <= dq;
        digit_cnt <= digit_cnt - 1'b1;
      end
    end
  end

  assign pdig  = 4'(dchunk - dq * 24'd10);
  assign digit = (pos == 6'd0 || pos > 6'(7 * NumChunks)) ? 4'd0 : pdig;

  assign status.exp_zero   = (exp_left == 64'd0);
  assign status.exp_lsb    = exp_left[0];
  assign status.exp_gt1    = (exp_left > 64'd1);
  assign status.split_done = (split_idx == IdxW'(NumChunks - 1));
  assign status.digit_done = !dinit && (digit_cnt == 6'd0);

`ifndef SYNTHESIS
  a_rem_lt_base: assert property (@(posedge clk)
    cmd.norm |-> (nr_fix < 26'(ChunkBase))) else $error("chunk not normalised");
  a_digit_range: assert property (@(posedge clk)
    cmd.digit_step && status.digit_done |-> (digit <= 4'd9)) else $error("bad digit");
  a_exp_shift: assert property (@(posedge clk)
    cmd.shift_exp |=> (exp_left == ($past(exp_left) >> 1))) else $error("shift");
`endif

endmodule

// ----- design/power_decimal_digit_extract_unit.sv -----
// channel | signals                                   | accept
// in      | in_valid, in_stall, base_value, power,    | in_valid && !in_stall
//         | digit_position                            |
// out     | out_valid, out_stall, digit               | out_valid && !out_stall
// One item at a time; the base is first split into 8 chunks, then per exponent
// bit a check, up to two 8-chunk multiplications (a clear, 36 products and a
// norm load, quotient, remainder and write step per chunk each) on the single
// shared multiplier, and a shift; then the digit is picked by division by ten.
// Synchronous reset returns the controller to idle.
// The result holds while out_stall is high; input is stalled while busy.
module power_decimal_digit_extract_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] base_value,
  input  logic [63:0] power,
  input  logic [5:0]  digit_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  digit
);
  import pdde_pkg::*;

  pdde_cmd_t    cmd;
  pdde_status_t status;

  pdde_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .status
  );

  pdde_dp u_dp (
    .clk, .base_value, .power, .digit_position, .cmd, .status, .digit
  );

endmodule

// ----- tb/sv/pdde_checker.sv -----
`timescale 1ns / 100ps

module pdde_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [30:0] base_value,
  input  logic [63:0] power,
  input  logic [5:0]  digit_position,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  digit,
  output int          fail_count,
  output int          pending
);
  import pdde_pkg::*;

  typedef logic [63:0] chunk_arr_t [NumChunks];

  logic [3:0] digit_q [$];

  function automatic chunk_arr_t mul_trunc(chunk_arr_t a, chunk_arr_t b);
    logic [63:0] sums [NumChunks];
    logic [63:0] carry;
    logic [63:0] v;
    chunk_arr_t r;
    carry = 0;
    for (int i = 0; i < NumChunks; i++) sums[i] = 0;
    for (int i = 0; i < NumChunks; i++)
      for (int j = 0; i + j < NumChunks; j++)
        sums[i+j] += a[i] * b[j];
    for (int i = 0; i < NumChunks; i++) begin
      v = sums[i] + carry;
      r[i] = v % 64'd10000000;
      carry = v / 64'd10000000;
    end
    return r;
  endfunction

  function automatic logic [3:0] power_digit(logic [30:0] b, logic [63:0] e,
                                             logic [5:0] pos);
    chunk_arr_t pw;
    chunk_arr_t sq;
    logic [63:0] rest;
    logic [63:0] c;
    int idx;
    int off;
    rest = 64'(b);
    for (int k = 0; k < NumChunks; k++) begin
      pw[k] = (k == 0) ? 64'd1 : 64'd0;
      sq[k] = rest % 64'd10000000;
      rest = rest / 64'd10000000;
    end
    while (e > 0) begin
      if (e[0]) pw = mul_trunc(pw, sq);
      if (e > 1) sq = mul_trunc(sq, sq);
      e = e >> 1;
    end
    if (pos == 0) return 4'd0;
    idx = (pos - 1) / 7;
    off = (pos - 1) % 7;
    if (idx >= NumChunks) return 4'd0;
    c = pw[idx];
    for (int k = 0; k < off; k++) c = c / 10;
    return 4'(c % 10);
  endfunction

  assign pending = digit_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        digit_q.push_back(power_digit(base_value, power, digit_position));
      if (out_valid && !out_stall) begin
        if (digit_q.size() == 0) begin
          $error("unexpected transaction: digit=%0d", digit);
          fail_count <= fail_count + 1;
        end else if (digit_q[0] !== digit) begin
          $error("digit mismatch: expected %0d actual %0d", digit_q[0], digit);
          fail_count <= fail_count + 1;
          void'(digit_q.pop_front());
        end else begin
          void'(digit_q.pop_front());
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [30:0] base_value;
  logic [63:0] power;
  logic [5:0]  digit_position;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  digit;
  int          fail_count;
  int          pending;
  int          cycle_count;
  logic [30:0] dir_base [$];
  logic [63:0] dir_exp [$];
  logic [5:0]  dir_pos [$];

  localparam int CycleLimit = 10000000;

  power_decimal_digit_extract_unit u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .base_value(base_value), .power(power), .digit_position(digit_position),
    .out_valid(out_valid), .out_stall(out_stall), .digit(digit)
  );

  pdde_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .base_value(base_value), .power(power), .digit_position(digit_position),
    .out_valid(out_valid), .out_stall(out_stall), .digit(digit),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stall pattern: quiet stretches and busy stretches
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if ((cycle_count / 300) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic send_item(logic [30:0] b, logic [63:0] e, logic [5:0] p);
    in_valid <= 1'b1;
    base_value <= b;
    power <= e;
    digit_position <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    base_value <= 31'($urandom);
    power <= {$urandom, $urandom};
    digit_position <= 6'($urandom);
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_exp();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 20));
      1: return 64'($urandom_range(0, 5000));
      2: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [30:0] rand_base();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 12));
      1: return 31'($urandom_range(0, 99999));
      default: return 31'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    cycle_count = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    base_value = '0;
    power = '0;
    digit_position = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_base = '{31'd0, 31'd0, 31'd7, 31'd2, 31'h7FFFFFFF, 31'h7FFFFFFF,
                 31'd2, 31'd3, 31'd10, 31'd10, 31'd10000000, 31'd1,
                 31'h7FFFFFFF, 31'd5, 31'd9, 31'd999, 31'd2, 31'd123456789};
    dir_exp  = '{64'd0, 64'd5, 64'd0, 64'd10, 64'd1, 64'hFFFFFFFFFFFFFFFF,
                 64'hFFFFFFFFFFFFFFFF, 64'h8000000000000000, 64'd55, 64'd56,
                 64'd8, 64'hFFFFFFFFFFFFFFFF, 64'd2, 64'd3, 64'd100, 64'd7,
                 64'd186, 64'h5555555555555555};
    dir_pos  = '{6'd1, 6'd3, 6'd2, 6'd0, 6'd10, 6'd56, 6'd57, 6'd63, 6'd56,
                 6'd56, 6'd50, 6'd1, 6'd19, 6'd1, 6'd7, 6'd21, 6'd8, 6'd42};
    foreach (dir_base[k]) send_item(dir_base[k], dir_exp[k], dir_pos[k]);

    for (int n = 0; n < 100; n += burst) begin
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst; k++)
        send_item(rand_base(), rand_exp(), 6'($urandom_range(0, 63)));
      if (n >= 60 && n < 68) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end else if ($urandom_range(0, 1)) begin
        idle_gap($urandom_range(1, 40));
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/pdde_pkg.sv
design/pdde_ctrl.sv
design/pdde_dp.sv
design/power_decimal_digit_extract_unit.sv
tb/sv/pdde_checker.sv
tb/sv/tb_top.sv
